[design/indexed_list_shift_table_assert.svh]
// Assertion macros for the list table RTL.
`ifndef INDEXED_LIST_SHIFT_TABLE_ASSERT_SVH
`define INDEXED_LIST_SHIFT_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ilst_pkg.sv]
`default_nettype none

package ilst_pkg;

	localparam int OP_W = 3;
	localparam int INDEX_W = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_READ    = 3'd0;
	localparam op_t OP_REPLACE = 3'd1;
	localparam op_t OP_INSERT  = 3'd2;
	localparam op_t OP_APPEND  = 3'd3;
	localparam op_t OP_REMOVE  = 3'd4;

endpackage

`default_nettype wire

[design/ilst_ram.sv]
`default_nettype none

module ilst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/indexed_list_shift_table.sv]
// Ordered list of up to DEPTH entries held in one single-port-write RAM, with a running
// count. Each item carries one operation (read, replace, insert, append, remove) and gives
// one result. The sequencer takes one item at a time and moves entries through the single
// RAM read port and write port, one entry per cycle. Read, replace, append and any failing
// operation skip the shift. Insert at index i below the count moves entries i
// through the last up by one, then writes the value at i; remove below the last entry
// moves the entries above i down by one. The result sits in an output register, so the
// next item may be taken while a result still waits for its transfer. No clearing pass:
// entries are undefined until written, and only written entries lie below the count.
`default_nettype none

`include "indexed_list_shift_table_assert.svh"

module indexed_list_shift_table #(
	parameter int DEPTH = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [ilst_pkg::OP_W-1:0]     op,
	input  wire logic [ilst_pkg::INDEX_W-1:0]  index,
	input  wire logic [ilst_pkg::VALUE_W-1:0]  value,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               ok,
	output logic      [ilst_pkg::VALUE_W-1:0]  read_value,
	output logic      [ilst_pkg::COUNT_W-1:0]  count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > ilst_pkg::INDEX_W) ? CW : ilst_pkg::INDEX_W;
	localparam int MW = (ENTRY_WIDTH > ilst_pkg::VALUE_W) ? ENTRY_WIDTH : ilst_pkg::VALUE_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INS   = 3'd1;
	localparam logic [2:0] ST_WRVAL = 3'd2;
	localparam logic [2:0] ST_REM   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]             state_q;
	logic [CW-1:0]          count_q;
	logic                   result_valid_q;
	logic [AW-1:0]          ptr_q;
	logic [AW-1:0]          idx_q;
	logic [ENTRY_WIDTH-1:0] val_q;
	logic                   ok_pend_q;
	logic                   rdsel_q;
	logic                   ok_q;
	logic [ilst_pkg::VALUE_W-1:0] read_value_q;
	logic [ilst_pkg::COUNT_W-1:0] count_out_q;

	logic                   accept;
	logic                   out_free;
	logic                   go_ok;
	logic [XW-1:0]          idx_x;
	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          idx_p1_x;
	logic [CW-1:0]          cnt_m1;
	logic [AW-1:0]          idx_a;
	logic [MW-1:0]          val_ext;
	logic [ENTRY_WIDTH-1:0] val_w;
	logic [MW-1:0]          rd_ext;
	logic                   ins_more;
	logic                   rem_more;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [ENTRY_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [ENTRY_WIDTH-1:0] ram_rdata;

	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	assign idx_x = XW'(index);
	assign cnt_x = XW'(count_q);
	assign idx_p1_x = idx_x + 1'b1;
	assign cnt_m1 = count_q - 1'b1;
	assign idx_a = idx_x[AW-1:0];
	assign val_ext = MW'(value);
	assign val_w = val_ext[ENTRY_WIDTH-1:0];
	assign rd_ext = MW'(ram_rdata);

	// another entry still to move during a shift
	assign ins_more = (ptr_q > idx_q);
	assign rem_more = ((CW'(ptr_q) + 1'b1) < count_q);

	always_comb begin
		go_ok = 1'b0;
		case (op)
			ilst_pkg::OP_READ,
			ilst_pkg::OP_REPLACE,
			ilst_pkg::OP_REMOVE: go_ok = (idx_x < cnt_x);
			ilst_pkg::OP_INSERT: go_ok = (idx_x <= cnt_x) && (count_q < CW'(DEPTH));
			ilst_pkg::OP_APPEND: go_ok = (count_q < CW'(DEPTH));
			default:             go_ok = 1'b0;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && go_ok) begin
					case (op)
						ilst_pkg::OP_READ: begin
							ram_re = 1'b1;
							ram_raddr = idx_a;
						end
						ilst_pkg::OP_REPLACE: begin
							ram_we = 1'b1;
							ram_waddr = idx_a;
							ram_wdata = val_w;
						end
						ilst_pkg::OP_APPEND: begin
							ram_we = 1'b1;
							ram_waddr = count_q[AW-1:0];
							ram_wdata = val_w;
						end
						ilst_pkg::OP_INSERT: begin
							if (idx_x == cnt_x) begin
								ram_we = 1'b1;
								ram_waddr = idx_a;
								ram_wdata = val_w;
							end else begin
								ram_re = 1'b1;
								ram_raddr = cnt_m1[AW-1:0];
							end
						end
						ilst_pkg::OP_REMOVE: begin
							if (idx_p1_x < cnt_x) begin
								ram_re = 1'b1;
								ram_raddr = idx_p1_x[AW-1:0];
							end
						end
						default: begin
							ram_re = 1'b0;
						end
					endcase
				end
			end
			ST_INS: begin
				// move the entry read last cycle up by one, fetch the next lower one
				ram_we = 1'b1;
				ram_waddr = ptr_q + 1'b1;
				ram_wdata = ram_rdata;
				if (ins_more) begin
					ram_re = 1'b1;
					ram_raddr = ptr_q - 1'b1;
				end
			end
			ST_WRVAL: begin
				ram_we = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = val_q;
			end
			ST_REM: begin
				ram_we = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				if (rem_more) begin
					ram_re = 1'b1;
					ram_raddr = ptr_q + 1'b1 + 1'b1;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIN;
						if (go_ok) begin
							case (op)
								ilst_pkg::OP_INSERT: begin
									count_q <= count_q + 1'b1;
									if (idx_x != cnt_x) begin
										state_q <= ST_INS;
									end
								end
								ilst_pkg::OP_APPEND: begin
									count_q <= count_q + 1'b1;
								end
								ilst_pkg::OP_REMOVE: begin
									count_q <= count_q - 1'b1;
									if (idx_p1_x < cnt_x) begin
										state_q <= ST_REM;
									end
								end
								default: begin
									state_q <= ST_FIN;
								end
							endcase
						end
					end
				end
				ST_INS: begin
					if (!ins_more) begin
						state_q <= ST_WRVAL;
					end
				end
				ST_WRVAL: begin
					state_q <= ST_FIN;
				end
				ST_REM: begin
					if (!rem_more) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q <= idx_a;
					val_q <= val_w;
					ok_pend_q <= go_ok;
					rdsel_q <= go_ok && (op == ilst_pkg::OP_READ);
					if (op == ilst_pkg::OP_INSERT) begin
						ptr_q <= cnt_m1[AW-1:0];
					end else begin
						ptr_q <= idx_a;
					end
				end
			end
			ST_INS: begin
				if (ins_more) begin
					ptr_q <= ptr_q - 1'b1;
				end
			end
			ST_REM: begin
				if (rem_more) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					ok_q <= ok_pend_q;
					read_value_q <= rdsel_q ? rd_ext[ilst_pkg::VALUE_W-1:0] : '0;
					count_out_q <= cnt_x[ilst_pkg::COUNT_W-1:0];
				end
			end
			default: begin
				ok_q <= ok_q;
			end
		endcase
	end

	ilst_ram #(
		.WIDTH(ENTRY_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign result_valid = result_valid_q;
	assign ok = ok_q;
	assign read_value = read_value_q;
	assign count = count_out_q;

	`ILST_ASSERT_NEXT(a_grow_count, clk, arst_n,
		accept && go_ok && (op == ilst_pkg::OP_INSERT || op == ilst_pkg::OP_APPEND),
		count_q == $past(count_q) + 1'b1, "count did not grow after insert or append")
	`ILST_ASSERT_NEXT(a_fail_keeps_count, clk, arst_n, accept && !go_ok,
		$stable(count_q), "failed operation changed the count")
	`ILST_ASSERT_NOW(a_fail_no_data, clk, arst_n, result_valid && !ok,
		read_value == '0, "failed result carries read data")
	`ILST_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		count_q <= CW'(DEPTH), "entry count above depth")

endmodule

`default_nettype wire
